// ===== src/drbm_pkg.sv =====
// ----------------------------------------------------------------------------
// drbm_pkg
// Shared types, widths and helpers for the decaying byte rate meter.
// ----------------------------------------------------------------------------
package drbm_pkg;

   // field widths
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 32;
   localparam int TIME_W  = 48;
   localparam int RATE_W  = 31;

   // microseconds per second and the product width count * scale
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] US_PER_SEC = SCALE_W'(1000000);
   localparam int PROD_W  = COUNT_W + SCALE_W;

   // rate lanes: audio, video, total
   localparam int RATE_LANES = 3;
   localparam int LANE_AUDIO = 0;
   localparam int LANE_VIDEO = 1;
   localparam int LANE_TOTAL = 2;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_AUDIO   = 2'd0,
      KIND_VIDEO   = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   // classified word held in the queue
   typedef struct packed {
      kind_type            kind;
      logic [TIME_W-1:0]   operand;
   } entry_type;

   // clamp a quotient to the largest reportable rate
   function automatic logic [RATE_W-1:0] sat_rate(input logic [PROD_W-1:0] quo);
      logic [RATE_W-1:0] res;
      if (quo[PROD_W-1:RATE_W] != '0) begin
         res = '1;
      end else begin
         res = quo[RATE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== src/decaying_byte_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// decaying_byte_rate_meter_top
// Audio, video and total byte rate meter over a decaying time window.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per valid/stall handshake. req_type selects audio
//   packet, video packet, rate query or restart; packets use
//   req_packet_bytes, queries and restarts use req_now_us.
//   rsp channel: one word per rate query with audio, video and total bytes
//   per second, each clamped to 2147483647.
//   Words enter a queue of QueueDepth entries; the back end takes one word
//   per cycle while not busy with a query, so packet words sustain one per
//   cycle. A query holds the back end while it takes the word, steps the
//   three lanes through the shared 32x20 multiplier, runs the bit-serial
//   divider (load, 52 quotient bits at one bit per lane per cycle, done)
//   and loads the result register. req_stall rises while the queue is full.
//   When rsp_stall holds a result, the back end keeps draining packet words;
//   a following query waits at the result register.
//   Reset clears the window start, both counters, the queue and rsp_valid.
// ----------------------------------------------------------------------------
module decaying_byte_rate_meter_top import drbm_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [COUNT_W-1:0]  req_packet_bytes,
   input  logic [TIME_W-1:0]   req_now_us,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RATE_W-1:0]   rsp_audio_rate,
   output logic [RATE_W-1:0]   rsp_video_rate,
   output logic [RATE_W-1:0]   rsp_total_rate
);

   logic       queue_full;
   logic       queue_empty;
   logic       push;
   logic       pop;
   entry_type  push_entry;
   entry_type  head;

   // front: accept and classify
   drbm_front u_front (
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_packet_bytes (req_packet_bytes),
      .req_now_us       (req_now_us),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decoupling queue
   drbm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // back: execute
   drbm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_audio_rate (rsp_audio_rate),
      .rsp_video_rate (rsp_video_rate),
      .rsp_total_rate (rsp_total_rate)
   );

endmodule

// ===== src/drbm_front.sv =====
// ----------------------------------------------------------------------------
// drbm_front
// Accepts request words and classifies them into queue entries.
// ----------------------------------------------------------------------------
module drbm_front import drbm_pkg::*; (
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [COUNT_W-1:0]  req_packet_bytes,
   input  logic [TIME_W-1:0]   req_now_us,
   input  logic                queue_full,
   output logic                push,
   output entry_type           push_entry
);

   kind_type kind;

   assign kind      = kind_type'(req_type);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && !reset;

   // packets carry their byte count, queries and restarts the time
   always_comb begin
      push_entry.kind = kind;
      unique case (kind) inside
         KIND_AUDIO, KIND_VIDEO: push_entry.operand = TIME_W'(req_packet_bytes);
         KIND_QUERY, KIND_RESTART: push_entry.operand = req_now_us;
         default: push_entry.operand = req_now_us;
      endcase
   end

endmodule

// ===== src/drbm_queue.sv =====
// ----------------------------------------------------------------------------
// drbm_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module drbm_queue import drbm_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output logic       empty,
   output logic       full
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   entry_type          slot_ff [Depth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(Depth));
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/drbm_div.sv =====
// ----------------------------------------------------------------------------
// drbm_div
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module drbm_div import drbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend [RATE_LANES],
   input  logic [TIME_W-1:0]   divisor,
   output logic                done,
   output logic [RATE_W-1:0]   quotient [RATE_LANES]
);

   localparam int STEP_W = $clog2(PROD_W);

   logic [PROD_W-1:0]  quo_ff [RATE_LANES];
   logic [PROD_W-1:0]  quo_in [RATE_LANES];
   logic [TIME_W-1:0]  rem_ff [RATE_LANES];
   logic [TIME_W-1:0]  rem_in [RATE_LANES];
   logic [TIME_W-1:0]  divisor_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;

   // one restoring step per lane: shift in the next dividend bit, try subtract
   always_comb begin
      logic [TIME_W:0] rem_sh;
      logic [TIME_W:0] diff;
      for (int i = 0; i < RATE_LANES; i++) begin
         rem_sh    = {rem_ff[i], quo_ff[i][PROD_W-1]};
         diff      = rem_sh - {1'b0, divisor_ff};
         if (rem_sh >= {1'b0, divisor_ff}) begin
            rem_in[i] = diff[TIME_W-1:0];
            quo_in[i] = {quo_ff[i][PROD_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_sh[TIME_W-1:0];
            quo_in[i] = {quo_ff[i][PROD_W-2:0], 1'b0};
         end
      end
   end

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // lane datapath
   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         for (int i = 0; i < RATE_LANES; i++) begin
            quo_ff[i] <= dividend[i];
            rem_ff[i] <= '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < RATE_LANES; i++) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign done = done_ff;

   // saturated rates
   always_comb begin
      for (int i = 0; i < RATE_LANES; i++) begin
         quotient[i] = sat_rate(quo_ff[i]);
      end
   end

endmodule

// ===== src/drbm_back.sv =====
// ----------------------------------------------------------------------------
// drbm_back
// Executes queued words: counter updates, restarts and rate queries.
// ----------------------------------------------------------------------------
module drbm_back import drbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  entry_type           head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RATE_W-1:0]   rsp_audio_rate,
   output logic [RATE_W-1:0]   rsp_video_rate,
   output logic [RATE_W-1:0]   rsp_total_rate
);

   localparam int MUL_W = $clog2(RATE_LANES);

   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0]  audio_ff, audio_in;
   logic [COUNT_W-1:0]  video_ff, video_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [COUNT_W-1:0]  cnt_ff [RATE_LANES];
   logic [COUNT_W-1:0]  cnt_in [RATE_LANES];
   logic [PROD_W-1:0]   prod_ff [RATE_LANES];
   logic [MUL_W-1:0]    mul_idx_ff, mul_idx_in;
   logic                div_start_ff, div_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic                mul_step;
   logic [PROD_W-1:0]   mul_prod;
   logic                div_done;
   logic [RATE_W-1:0]   div_quo [RATE_LANES];
   logic [RATE_W-1:0]   audio_rate_ff, video_rate_ff, total_rate_ff;

   assign pop      = (state_ff == ST_RUN) && !empty;
   assign mul_step = (state_ff == ST_MUL);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // one product per cycle in ST_MUL, lanes shift through the multiplier
   assign mul_prod = PROD_W'(cnt_ff[0]) * PROD_W'(US_PER_SEC);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      audio_in     = audio_ff;
      video_in     = video_ff;
      elapsed_in   = elapsed_ff;
      mul_idx_in   = mul_idx_ff;
      div_start_in = 1'b0;
      for (int i = 0; i < RATE_LANES; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_RUN: begin
            if (!empty) begin
               unique case (head.kind)
                  KIND_AUDIO: audio_in = audio_ff + head.operand[COUNT_W-1:0];
                  KIND_VIDEO: video_in = video_ff + head.operand[COUNT_W-1:0];
                  KIND_RESTART: begin
                     start_in = head.operand;
                     audio_in = '0;
                     video_in = '0;
                  end
                  KIND_QUERY: begin
                     elapsed_in = (head.operand > start_ff) ?
                                  head.operand - start_ff : TIME_W'(1);
                     cnt_in[LANE_AUDIO] = audio_ff;
                     cnt_in[LANE_VIDEO] = video_ff;
                     cnt_in[LANE_TOTAL] = audio_ff + video_ff;
                     audio_in   = audio_ff >> 1;
                     video_in   = video_ff >> 1;
                     mul_idx_in = '0;
                     state_in   = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            // window start moves by half the elapsed time
            if (mul_idx_ff == '0) begin
               start_in = start_ff + (elapsed_ff >> 1);
            end
            for (int i = 0; i < RATE_LANES - 1; i++) begin
               cnt_in[i] = cnt_ff[i+1];
            end
            mul_idx_in = mul_idx_ff + 1'b1;
            if (mul_idx_ff == MUL_W'(RATE_LANES - 1)) begin
               div_start_in = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         start_ff     <= '0;
         audio_ff     <= '0;
         video_ff     <= '0;
         mul_idx_ff   <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         audio_ff     <= audio_in;
         video_ff     <= video_in;
         mul_idx_ff   <= mul_idx_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // query datapath
   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      for (int i = 0; i < RATE_LANES; i++) begin
         cnt_ff[i] <= cnt_in[i];
      end
      if (mul_step) begin
         for (int i = 0; i < RATE_LANES - 1; i++) begin
            prod_ff[i] <= prod_ff[i+1];
         end
         prod_ff[RATE_LANES-1] <= mul_prod;
      end
   end

   drbm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         audio_rate_ff <= div_quo[LANE_AUDIO];
         video_rate_ff <= div_quo[LANE_VIDEO];
         total_rate_ff <= div_quo[LANE_TOTAL];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_audio_rate = audio_rate_ff;
   assign rsp_video_rate = video_rate_ff;
   assign rsp_total_rate = total_rate_ff;

endmodule

// ===== src/drbm_checker.sv =====
// ----------------------------------------------------------------------------
// drbm_checker
// Port-level checks for the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module drbm_checker import drbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [COUNT_W-1:0]  req_packet_bytes,
   input  logic [TIME_W-1:0]   req_now_us,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [RATE_W-1:0]   rsp_audio_rate,
   input  logic [RATE_W-1:0]   rsp_video_rate,
   input  logic [RATE_W-1:0]   rsp_total_rate
);

   // reset empties the queue and clears rsp_valid
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear rsp_valid or req_stall");

   // a stalled request keeps its word
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_type)
         && $stable(req_packet_bytes) && $stable(req_now_us))
      else $error("stalled request changed");

   // a held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_audio_rate)
         && $stable(rsp_video_rate) && $stable(rsp_total_rate))
      else $error("stalled result changed");

   // the queue only fills when a word was just accepted
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("queue filled without an accepted word");

   // a query passes through the multiplier and divider, so no result right after reset
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result appeared too soon after reset");

endmodule

bind decaying_byte_rate_meter_top drbm_checker u_drbm_checker (.*);
